// File: rtl/core/pf_pkg.sv
package pf_pkg;

   localparam int VALUE_WIDTH = 32;
   // trial divisors never exceed the square root of the cofactor, plus one step
   localparam int D_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   typedef struct packed {
      logic                   vld;
      logic [VALUE_WIDTH-1:0] factor;
      logic                   valid_res;
      logic                   last;
   } pf_emit_type;

endpackage

// File: rtl/core/prime_factorizer_core.sv
// Prime factorizer by trial division.
// Input channel req_valid/req_ready/req_value: one unsigned integer per transfer.
// Result channel rsp_valid/rsp_ready: one prime factor per transfer in
// nondecreasing order, repeated per multiplicity; rsp_last marks the final one.
// Inputs 0 and 1 give a single result with rsp_valid_res = 0 and rsp_last = 1.
// One item is worked at a time; req_ready is high only while no item is open.
// Each trial divisor takes one pass of the bit-serial divider, which
// produces one quotient bit per cycle. Divisors run from 2 up to the square
// root of the remaining cofactor, and each factor found costs one more trial.
// Each factor is held back until the next one is found so the last one can be marked; a result
// sits in the output register until taken, and a stalled receiver halts the
// search only when a new factor has to be handed over.
// Reset returns the block to idle and drops any result not yet transferred.
module prime_factorizer_core import pf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_valid_res,
   output logic                   rsp_last
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_WAIT  = 8'b0000_0100,
      S_PUSH  = 8'b0000_1000,
      S_FLUSH = 8'b0001_0000,
      S_TAIL  = 8'b0010_0000,
      S_LAST  = 8'b0100_0000,
      S_LOW   = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] rest_ff, rest_in;
   logic [D_WIDTH-1:0]     d_ff, d_in;
   logic                   fresh_ff, fresh_in;
   logic [D_WIDTH-1:0]     pend_ff, pend_in;
   logic                   pend_vld_ff, pend_vld_in;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] quo;
   logic [D_WIDTH-1:0]     rem;
   logic                   can_load;
   pf_emit_type            emit;
   logic                   past_root;
   logic                   rest_big;
   logic [VALUE_WIDTH-1:0] pend_wide;

   pf_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rest_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   pf_rsp_reg u_rsp (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_factor    (rsp_factor),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last)
   );

   assign req_ready = state_ff == S_IDLE;
   assign div_start = state_ff == S_DIV;
   assign pend_wide = {{(VALUE_WIDTH - D_WIDTH){1'b0}}, pend_ff};
   // loop bound d <= rest / d, tested only on the first division by a divisor
   assign past_root = {{(VALUE_WIDTH - D_WIDTH){1'b0}}, d_ff} > quo;
   assign rest_big  = rest_ff > VALUE_WIDTH'(1);

   always_comb begin
      emit = '0;
      case (state_ff)
         S_PUSH, S_FLUSH: begin
            emit.vld       = 1'b1;
            emit.factor    = pend_wide;
            emit.valid_res = 1'b1;
         end
         S_LAST: begin
            emit.vld       = 1'b1;
            emit.factor    = pend_wide;
            emit.valid_res = 1'b1;
            emit.last      = 1'b1;
         end
         S_TAIL: begin
            emit.vld       = 1'b1;
            emit.factor    = rest_ff;
            emit.valid_res = 1'b1;
            emit.last      = 1'b1;
         end
         S_LOW: begin
            emit.vld  = 1'b1;
            emit.last = 1'b1;
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      rest_in     = rest_ff;
      d_in        = d_ff;
      fresh_in    = fresh_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rest_in     = req_value;
               d_in        = D_WIDTH'(2);
               fresh_in    = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = (req_value < VALUE_WIDTH'(2)) ? S_LOW : S_DIV;
            end
         end
         S_DIV: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (fresh_ff && past_root) begin
                  if (rest_big) begin
                     state_in = pend_vld_ff ? S_FLUSH : S_TAIL;
                  end else begin
                     state_in = S_LAST;
                  end
               end else if (rem == '0) begin
                  // divide out d and try it again
                  rest_in  = quo;
                  fresh_in = 1'b0;
                  if (pend_vld_ff) begin
                     state_in = S_PUSH;
                  end else begin
                     pend_in     = d_ff;
                     pend_vld_in = 1'b1;
                     state_in    = S_DIV;
                  end
               end else begin
                  d_in     = d_ff + 1'b1;
                  fresh_in = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_PUSH: begin
            if (can_load) begin
               pend_in  = d_ff;
               state_in = S_DIV;
            end
         end
         S_FLUSH: begin
            if (can_load) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL, S_LAST, S_LOW: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_vld_ff <= 1'b0;
         fresh_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         fresh_ff    <= fresh_in;
      end
      rest_ff <= rest_in;
      d_ff    <= d_in;
      pend_ff <= pend_in;
   end

endmodule

// File: rtl/core/pf_divider.sv
module pf_divider import pf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [D_WIDTH-1:0]     divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [D_WIDTH-1:0]     remainder
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [D_WIDTH-1:0]     rem_ff, rem_in;
   logic [D_WIDTH-1:0]     dvs_ff, dvs_in;
   logic [D_WIDTH:0]       shifted;
   logic [D_WIDTH:0]       diff;
   logic                   fits;

   // one quotient bit per cycle, dividend shifts out of the top of quo_ff
   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[D_WIDTH-1:0] : shifted[D_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/pf_rsp_reg.sv
module pf_rsp_reg import pf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  pf_emit_type            emit,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_valid_res,
   output logic                   rsp_last
);

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] factor_ff, factor_in;
   logic                   res_ff, res_in;
   logic                   last_ff, last_in;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      factor_in = factor_ff;
      res_in    = res_ff;
      last_in   = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (emit.vld && can_load) begin
         valid_in  = 1'b1;
         factor_in = emit.factor;
         res_in    = emit.valid_res;
         last_in   = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      factor_ff <= factor_in;
      res_ff    <= res_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_factor    = factor_ff;
   assign rsp_valid_res = res_ff;
   assign rsp_last      = last_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pf_pkg::*;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      int unsigned            gap;
   } value_item_type;

   typedef struct {
      logic [VALUE_WIDTH-1:0] factor;
      logic                   valid_res;
      logic                   last;
   } factor_rec_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VALUE_WIDTH-1:0] rsp_factor;
   logic                   rsp_valid_res;
   logic                   rsp_last;

   value_item_type  values_to_send[$];
   factor_rec_type  expected_factors[$];
   value_item_type  next_item;

   int unsigned values_queued = 0;
   int unsigned values_factored = 0;
   int unsigned factors_checked = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;

   prime_factorizer_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_factor    (rsp_factor),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Trial division on a wide copy; every divisor is split out as often as it goes.
   function automatic void predict_factors(input logic [VALUE_WIDTH-1:0] value);
      logic [63:0] rest;
      logic [63:0] d;
      factor_rec_type found[$];
      factor_rec_type rec;
      rest = 64'(value);
      if (rest < 64'd2) begin
         rec.factor = '0;
         rec.valid_res = 1'b0;
         rec.last = 1'b1;
         expected_factors.push_back(rec);
         return;
      end
      for (d = 64'd2; d <= rest / d; d++) begin
         while (rest % d == 64'd0) begin
            rest = rest / d;
            rec.factor = VALUE_WIDTH'(d);
            rec.valid_res = 1'b1;
            rec.last = 1'b0;
            found.push_back(rec);
         end
      end
      if (rest > 64'd1) begin
         rec.factor = VALUE_WIDTH'(rest);
         rec.valid_res = 1'b1;
         rec.last = 1'b0;
         found.push_back(rec);
      end
      found[found.size() - 1].last = 1'b1;
      foreach (found[k]) expected_factors.push_back(found[k]);
   endfunction

   // Product of small numbers: wide values whose search still ends early.
   function automatic logic [VALUE_WIDTH-1:0] smooth_value();
      logic [63:0] prod;
      logic [63:0] f;
      int          n;
      prod = 64'd1;
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
         f = 64'($urandom_range(2, 255));
         if (prod * f <= 64'hFFFF_FFFF) prod = prod * f;
      end
      return prod[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0: return VALUE_WIDTH'($urandom_range(0, 1));
         1, 2: return VALUE_WIDTH'($urandom_range(2, 4095));
         3, 4: return VALUE_WIDTH'($urandom_range(1, 65535)) << $urandom_range(0, 16);
         9: return VALUE_WIDTH'($urandom_range(2, 65535));
         default: return smooth_value();
      endcase
   endfunction

   task automatic queue_value(input logic [VALUE_WIDTH-1:0] value, input int unsigned gap);
      value_item_type item;
      item.value = value;
      item.gap = gap;
      values_to_send.push_back(item);
      values_queued++;
   endtask

   // Sender: hold the payload until the transfer, then idle for the drawn gap.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait = req_wait - 1;
         end else if (values_to_send.size() > 0) begin
            next_item = values_to_send.pop_front();
            req_valid <= 1'b1;
            req_value <= next_item.value;
            req_wait = next_item.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: draw a stall after every transfer, except in calm stretches.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken)
            rsp_wait = (((factors_checked / 40) % 3) == 2) ? 0 : $urandom_range(0, 4);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            predict_factors(req_value);
            values_factored++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_factors.size() == 0) begin
               $error("unexpected factor transfer: factor %0d valid_res %0d last %0d",
                      rsp_factor, rsp_valid_res, rsp_last);
               err_count++;
            end else begin
               if (rsp_factor !== expected_factors[0].factor) begin
                  $error("factor: expected %0d, actual %0d",
                         expected_factors[0].factor, rsp_factor);
                  err_count++;
               end
               if (rsp_valid_res !== expected_factors[0].valid_res) begin
                  $error("valid_res: expected %0d, actual %0d",
                         expected_factors[0].valid_res, rsp_valid_res);
                  err_count++;
               end
               if (rsp_last !== expected_factors[0].last) begin
                  $error("last: expected %0d, actual %0d",
                         expected_factors[0].last, rsp_last);
                  err_count++;
               end
               void'(expected_factors.pop_front());
            end
            factors_checked++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_ready = 1'b0;

      // Corner values: below two, small primes, powers and composites, all-ones and alternating bits.
      queue_value(32'd0, $urandom_range(0, 4));
      queue_value(32'd1, $urandom_range(0, 4));
      queue_value(32'd2, $urandom_range(0, 4));
      queue_value(32'd3, $urandom_range(0, 4));
      queue_value(32'd4, $urandom_range(0, 4));
      queue_value(32'd8, $urandom_range(0, 4));
      queue_value(32'd12, 0);
      queue_value(32'd49, 0);
      queue_value(32'd97, 0);
      queue_value(32'd360, 0);
      queue_value(32'd1001, $urandom_range(0, 4));
      queue_value(32'd65521, $urandom_range(0, 4));
      queue_value(32'd65536, $urandom_range(0, 4));
      queue_value(32'h8000_0000, $urandom_range(0, 4));
      queue_value(32'hFFFF_FFFF, $urandom_range(0, 4));
      queue_value(32'hAAAA_AAAA, $urandom_range(0, 4));
      queue_value(32'h5555_5555, $urandom_range(0, 4));
      queue_value(32'hFFFE_0001, $urandom_range(0, 4));
      queue_value(32'hFFFF_0000, $urandom_range(0, 4));

      for (int i = 0; i < 100; i++)
         queue_value(random_value(), (((i / 20) % 3) == 1) ? 0 : $urandom_range(0, 4));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!(values_factored == values_queued && expected_factors.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Factored %0d values into %0d checked transfers in %0d cycles",
               values_factored, factors_checked, cycle_count);
      if (err_count == 0 && expected_factors.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
rtl/core/pf_pkg.sv
rtl/core/pf_divider.sv
rtl/core/pf_rsp_reg.sv
rtl/core/prime_factorizer_core.sv
tb/tb_top.sv
